// File: design/mtmd5_pkg.sv
`timescale 1ns / 1ps
package mtmd5_pkg;

  localparam int MaxHeight = 6;
  localparam int HashBytes = 16;
  localparam int NodesPerTree = 1 << MaxHeight;
  localparam int NodeAw = MaxHeight + 1;

  typedef struct packed {
    logic       cmd;
    logic       tree_select;
    logic [5:0] block_number;
    logic [7:0] data_byte;
    logic [5:0] start_node;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] root_hash_high;
    logic [63:0] root_hash_low;
    logic        root_valid;
    logic [5:0]  diff_block;
  } rsp_t;

  localparam logic [2:0] StUpdated = 3'd0;
  localparam logic [2:0] StCmpDone = 3'd1;
  localparam logic [2:0] StBadBlock = 3'd2;
  localparam logic [2:0] StBadCfg = 3'd3;
  localparam logic [2:0] StBadNode = 3'd4;

  localparam logic [1:0] RegHeight = 2'd0;
  localparam logic [1:0] RegLeaves = 2'd1;
  localparam logic [1:0] RegBlkBytes = 2'd2;

  localparam logic [127:0] Md5Init = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
          32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
          32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
          32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
          32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
          32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
          32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
          32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
          32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
          32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
          32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
          32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
          32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
          32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
          32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
          32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[{i[5:4], i[1:0]}];
  endfunction

  // message word index for round i
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] r;
    unique case (i[5:4])
      2'd0: r = i[3:0];
      2'd1: r = 4'(5 * i[3:0] + 1);
      2'd2: r = 4'(3 * i[3:0] + 5);
      default: r = 4'(7 * i[3:0]);
    endcase
    return r;
  endfunction

  // byte-swap the four-word chain value into big-endian digest order
  function automatic logic [127:0] md5_digest(input logic [127:0] h);
    logic [127:0] d;
    for (int b = 0; b < 16; b++) begin
      d[127 - 8*b -: 8] = h[8*b +: 8];
    end
    return d;
  endfunction

endpackage

// File: design/merkle_tree_md5_update_compare_core.sv
`timescale 1ns / 1ps
// Channel  | valid        | stall        | payload
// request  | req_valid_i  | req_stall_o  | req_i  (req_t)
// response | rsp_valid_o  | rsp_stall_i  | rsp_o  (rsp_t)
// config   | APB psel/penable/pwrite/paddr/pwdata/prdata/pready
// A data byte is taken while idle; a byte that ends a 64-byte chunk runs it through the
// shared MD5 round unit (one round per cycle). Finishing a block costs one or two
// chunks, then each tree level costs child reads plus, if both are valid, one chunk.
// A compare reads one node pair per step of the walk (pop, read, compare). Reset clears the valid
// bits and control state at once; hashes are left undefined. A held result stalls
// new requests, and new requests also wait while the unit is busy.
module merkle_tree_md5_update_compare_core
  import mtmd5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  req_t        req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000000000000001,
    S_ROUND  = 16'b0000000000000010,
    S_ADD    = 16'b0000000000000100,
    S_PAD    = 16'b0000000000001000,
    S_LEAF   = 16'b0000000000010000,
    S_UPRD   = 16'b0000000000100000,
    S_UPL    = 16'b0000000001000000,
    S_UPR    = 16'b0000000010000000,
    S_UPW    = 16'b0000000100000000,
    S_ROOTRD = 16'b0000001000000000,
    S_ROOT   = 16'b0000010000000000,
    S_POP    = 16'b0000100000000000,
    S_CMP    = 16'b0001000000000000,
    S_CMPD   = 16'b0010000000000000,
    S_OUT    = 16'b0100000000000000,
    S_NODEH  = 16'b1000000000000000
  } state_e;

  // chunk source: data block, or node hash pair
  typedef enum logic [1:0] {
    RET_BYTE = 2'b01,
    RET_NODE = 2'b10
  } ret_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0]  height_q;
  logic [5:0]  leaves_q;
  logic [15:0] blk_bytes_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 3'd4;
      leaves_q <= 6'd8;
      blk_bytes_q <= 16'd1024;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegHeight:   height_q <= pwdata[2:0];
        RegLeaves:   leaves_q <= pwdata[5:0];
        RegBlkBytes: blk_bytes_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegHeight:   prdata = {29'd0, height_q};
      RegLeaves:   prdata = {26'd0, leaves_q};
      RegBlkBytes: prdata = {16'd0, blk_bytes_q};
      default:     prdata = '0;
    endcase
  end

  logic cfg_bad;
  logic [6:0] half_leaves;
  assign half_leaves = 7'(7'd1 << (height_q - 3'd1));
  assign cfg_bad = (height_q == 3'd0) || (height_q > 3'(MaxHeight)) ||
                   ({1'b0, leaves_q} > half_leaves);

  // node storage: one memory of hashes and flop valid bits
  logic [127:0] hash_mem [2*NodesPerTree];
  logic [NodeAw-1:0] mem_raddr, mem_waddr;
  logic [127:0] mem_wdata, mem_rdata_q;
  logic         mem_we;
  logic [2*NodesPerTree-1:0] valid_q;
  logic         vset;
  logic [NodeAw-1:0] vaddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) hash_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= hash_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (vset) valid_q[vaddr] <= 1'b1;
  end

  // message buffer of the current chunk, 16 words little-endian
  logic [31:0] msg_q [16];
  logic [31:0] msg_d [16];

  // md5 chain and working registers
  logic [127:0] chain_q, chain_d;
  logic [31:0] a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  logic [5:0]  rnd_q, rnd_d;
  ret_e        ret_q, ret_d;
  logic        pad_two_q, pad_two_d;

  // block state
  logic [15:0] taken_q, taken_d;
  logic [5:0]  cur_blk_q, cur_blk_d;
  logic        cur_tree_q, cur_tree_d;
  logic [15:0] fin_len_q, fin_len_d;

  // path and walk state
  logic [5:0]  node_q, node_d;
  logic [6:0]  last_q, last_d;
  logic [127:0] left_q, left_d;
  logic        lv_q, lv_d, rv_q, rv_d;
  logic [6:0]  stack_q [MaxHeight];
  logic [6:0]  stack_d [MaxHeight];
  logic [2:0]  sp_q, sp_d;
  logic [6:0]  wnode_q, wnode_d;

  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  assign rsp_o = rsp_q;
  assign rsp_valid_o = rsp_valid_q;
  assign req_stall_o = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall_i);

  logic req_acc;
  assign req_acc = req_valid_i && !req_stall_o;

  // shared round unit
  logic [31:0] f_val, f_sum, rot;
  logic [4:0]  sh;
  always_comb begin
    unique case (rnd_q[5:4])
      2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1: f_val = (d_q & b_q) | (~d_q & c_q);
      2'd2: f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    f_sum = f_val + a_q + md5_k(rnd_q) + msg_q[md5_g(rnd_q)];
    sh = md5_s(rnd_q);
    rot = (f_sum << sh) | (f_sum >> (6'd32 - {1'b0, sh}));
  end

  logic [127:0] chain_sum;
  assign chain_sum = {chain_q[127:96] + d_q, chain_q[95:64] + c_q,
                      chain_q[63:32] + b_q, chain_q[31:0] + a_q};

  logic [6:0] first_leaf;
  assign first_leaf = half_leaves;
  logic [6:0] top_node;
  assign top_node = 7'((8'd1 << height_q) - 8'd1);

  logic [15:0] taken_inc;
  assign taken_inc = taken_q + 16'd1;

  logic [6:0] lchild, rchild;
  assign lchild = {node_q, 1'b0};
  assign rchild = {node_q, 1'b1};

  logic [63:0] bitlen;
  assign bitlen = {45'd0, fin_len_q, 3'd0};

  always_comb begin
    logic [5:0] pos;
    logic [127:0] dig;
    logic [6:0] wl;
    logic cv0, cv1, differ;
    state_d = state_q;
    chain_d = chain_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q;
    rnd_d = rnd_q;
    ret_d = ret_q;
    pad_two_d = pad_two_q;
    taken_d = taken_q;
    cur_blk_d = cur_blk_q;
    cur_tree_d = cur_tree_q;
    fin_len_d = fin_len_q;
    node_d = node_q;
    last_d = last_q;
    left_d = left_q;
    lv_d = lv_q; rv_d = rv_q;
    sp_d = sp_q;
    wnode_d = wnode_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    for (int w = 0; w < 16; w++) msg_d[w] = msg_q[w];
    for (int w = 0; w < MaxHeight; w++) stack_d[w] = stack_q[w];
    mem_raddr = '0;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    vset = 1'b0;
    vaddr = '0;
    pos = '0;
    dig = '0;
    wl = '0;
    cv0 = 1'b0; cv1 = 1'b0; differ = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          rsp_d = '0;
          if (req_i.cmd) begin
            if (cfg_bad) begin
              rsp_d.status = StBadCfg;
              state_d = S_OUT;
            end else if (req_i.start_node == 6'd0 ||
                         {1'b0, req_i.start_node} > top_node) begin
              rsp_d.status = StBadNode;
              state_d = S_OUT;
            end else begin
              rsp_d.status = StCmpDone;
              stack_d[0] = {1'b0, req_i.start_node};
              sp_d = 3'd1;
              state_d = S_POP;
            end
          end else begin
            if (taken_q == 16'd0) begin
              cur_blk_d = req_i.block_number;
              cur_tree_d = req_i.tree_select;
              chain_d = Md5Init;
            end
            pos = taken_q[5:0];
            msg_d[pos[5:2]][8*pos[1:0] +: 8] = req_i.data_byte;
            taken_d = taken_inc;
            fin_len_d = taken_inc;
            if (taken_inc[5:0] == 6'd0) begin
              {d_d, c_d, b_d, a_d} = (taken_q == 16'd0) ? Md5Init : chain_q;
              rnd_d = '0;
              ret_d = RET_BYTE;
              pad_two_d = 1'b0;
              state_d = S_ROUND;
            end else if (taken_inc >= blk_bytes_q) begin
              state_d = S_PAD;
            end
          end
        end
      end

      S_ROUND: begin
        a_d = d_q; d_d = c_q; c_d = b_q;
        b_d = b_q + rot;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = S_ADD;
      end

      S_ADD: begin
        chain_d = chain_sum;
        if (ret_q == RET_NODE) begin
          state_d = S_UPW;
        end else if (pad_two_q) begin
          state_d = S_LEAF;
        end else if (fin_len_q == taken_q && taken_q < blk_bytes_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PAD;
        end
      end

      // build the final padded chunk(s) in place
      S_PAD: begin
        pos = fin_len_q[5:0];
        if (!pad_two_q && (taken_q != 16'd0)) begin
          // first padding pass: place the marker and clear the tail
          for (int b = 0; b < 64; b++) begin
            if (6'(b) == pos) msg_d[b/4][8*(b%4) +: 8] = 8'h80;
            else if (6'(b) > pos) msg_d[b/4][8*(b%4) +: 8] = 8'h00;
          end
          taken_d = '0;
          if (pos > 6'd55) begin
            {d_d, c_d, b_d, a_d} = chain_q;
            rnd_d = '0;
            ret_d = RET_BYTE;
            pad_two_d = 1'b0;
            fin_len_d = fin_len_q;
            // after this chunk, run a length-only chunk
            state_d = S_ROUND;
            taken_d = '0;
          end else begin
            msg_d[14] = bitlen[31:0];
            msg_d[15] = bitlen[63:32];
            {d_d, c_d, b_d, a_d} = chain_q;
            rnd_d = '0;
            ret_d = RET_BYTE;
            pad_two_d = 1'b1;
            state_d = S_ROUND;
          end
        end else begin
          // second padding chunk: zeros and length
          for (int w = 0; w < 14; w++) msg_d[w] = '0;
          msg_d[14] = bitlen[31:0];
          msg_d[15] = bitlen[63:32];
          {d_d, c_d, b_d, a_d} = chain_q;
          rnd_d = '0;
          ret_d = RET_BYTE;
          pad_two_d = 1'b1;
          state_d = S_ROUND;
        end
      end

      // digest ready: check and write the leaf
      S_LEAF: begin
        pad_two_d = 1'b0;
        taken_d = '0;
        rsp_d = '0;
        if (cfg_bad || blk_bytes_q == 16'd0) begin
          rsp_d.status = StBadCfg;
          state_d = S_OUT;
        end else if (cur_blk_q == 6'd0 || cur_blk_q > leaves_q) begin
          rsp_d.status = StBadBlock;
          state_d = S_OUT;
        end else begin
          wl = first_leaf + {1'b0, cur_blk_q} - 7'd1;
          mem_we = 1'b1;
          mem_waddr = {cur_tree_q, wl[5:0]};
          mem_wdata = md5_digest(chain_q);
          vset = 1'b1;
          vaddr = {cur_tree_q, wl[5:0]};
          node_d = wl[6:1];
          last_d = first_leaf + {1'b0, leaves_q} - 7'd1;
          rsp_d.status = StUpdated;
          state_d = (wl[6:1] == 6'd0) ? S_ROOTRD : S_UPRD;
        end
      end

      S_UPRD: begin
        mem_raddr = {cur_tree_q, lchild[5:0]};
        lv_d = (lchild <= last_q) && valid_q[{cur_tree_q, lchild[5:0]}];
        rv_d = (rchild <= last_q) && valid_q[{cur_tree_q, rchild[5:0]}];
        state_d = S_UPL;
      end

      S_UPL: begin
        mem_raddr = {cur_tree_q, rchild[5:0]};
        left_d = mem_rdata_q;
        state_d = S_UPR;
      end

      S_UPR: begin
        if (lv_q && rv_q) begin
          // left||right, then padding, in one chunk
          for (int w = 0; w < 4; w++) begin
            msg_d[w] = {left_q[127-32*w-24 -: 8], left_q[127-32*w-16 -: 8],
                        left_q[127-32*w-8 -: 8], left_q[127-32*w -: 8]};
            msg_d[4+w] = {mem_rdata_q[127-32*w-24 -: 8], mem_rdata_q[127-32*w-16 -: 8],
                          mem_rdata_q[127-32*w-8 -: 8], mem_rdata_q[127-32*w -: 8]};
          end
          msg_d[8] = 32'h00000080;
          for (int w = 9; w < 14; w++) msg_d[w] = '0;
          msg_d[14] = 32'd256;
          msg_d[15] = '0;
          chain_d = Md5Init;
          {d_d, c_d, b_d, a_d} = Md5Init;
          rnd_d = '0;
          ret_d = RET_NODE;
          state_d = S_ROUND;
        end else if (lv_q) begin
          mem_we = 1'b1;
          mem_waddr = {cur_tree_q, node_q};
          mem_wdata = left_q;
          vset = 1'b1;
          vaddr = {cur_tree_q, node_q};
          node_d = node_q >> 1;
          state_d = (node_q[5:1] == 5'd0) ? S_ROOTRD : S_UPRD;
        end else begin
          node_d = node_q >> 1;
          state_d = (node_q[5:1] == 5'd0) ? S_ROOTRD : S_UPRD;
        end
      end

      S_UPW: begin
        mem_we = 1'b1;
        mem_waddr = {cur_tree_q, node_q};
        mem_wdata = md5_digest(chain_q);
        vset = 1'b1;
        vaddr = {cur_tree_q, node_q};
        node_d = node_q >> 1;
        state_d = (node_q[5:1] == 5'd0) ? S_ROOTRD : S_UPRD;
      end

      S_ROOTRD: begin
        mem_raddr = {cur_tree_q, 6'd1};
        state_d = S_ROOT;
      end

      S_ROOT: begin
        if (valid_q[{cur_tree_q, 6'd1}]) begin
          rsp_d.root_valid = 1'b1;
          rsp_d.root_hash_high = mem_rdata_q[127:64];
          rsp_d.root_hash_low = mem_rdata_q[63:0];
        end
        state_d = S_OUT;
      end

      // pop a node pair for the walk
      S_POP: begin
        if (sp_q == 3'd0) begin
          state_d = S_OUT;
        end else begin
          wnode_d = stack_q[sp_q - 3'd1];
          sp_d = sp_q - 3'd1;
          mem_raddr = {1'b0, stack_q[sp_q - 3'd1][5:0]};
          state_d = S_CMP;
        end
      end

      S_CMP: begin
        mem_raddr = {1'b1, wnode_q[5:0]};
        left_d = mem_rdata_q;
        state_d = S_CMPD;
      end

      S_CMPD: begin
        cv0 = valid_q[{1'b0, wnode_q[5:0]}];
        cv1 = valid_q[{1'b1, wnode_q[5:0]}];
        differ = (cv0 != cv1) || (cv0 && (left_q != mem_rdata_q));
        if (!differ) begin
          state_d = S_POP;
        end else if ({wnode_q, 1'b0} > {1'b0, top_node}) begin
          rsp_d.diff_block = 6'(wnode_q - first_leaf + 7'd1);
          state_d = S_OUT;
        end else if (sp_q + 3'd2 > 3'(MaxHeight)) begin
          state_d = S_OUT;
        end else begin
          stack_d[sp_q] = {wnode_q[5:0], 1'b1};
          stack_d[sp_q + 3'd1] = {wnode_q[5:0], 1'b0};
          sp_d = sp_q + 3'd2;
          state_d = S_POP;
        end
      end

      S_OUT: begin
        if (!(rsp_valid_q && rsp_stall_i)) begin
          rsp_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_NODEH: state_d = S_IDLE;

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      taken_q <= '0;
      cur_blk_q <= '0;
      cur_tree_q <= 1'b0;
      chain_q <= Md5Init;
      rsp_valid_q <= 1'b0;
      pad_two_q <= 1'b0;
      ret_q <= RET_BYTE;
      sp_q <= '0;
      rnd_q <= '0;
      fin_len_q <= '0;
    end else begin
      state_q <= state_d;
      taken_q <= taken_d;
      cur_blk_q <= cur_blk_d;
      cur_tree_q <= cur_tree_d;
      chain_q <= chain_d;
      rsp_valid_q <= rsp_valid_d;
      pad_two_q <= pad_two_d;
      ret_q <= ret_d;
      sp_q <= sp_d;
      rnd_q <= rnd_d;
      fin_len_q <= fin_len_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    node_q <= node_d;
    last_q <= last_d;
    left_q <= left_d;
    lv_q <= lv_d; rv_q <= rv_d;
    wnode_q <= wnode_d;
    rsp_q <= rsp_d;
    for (int w = 0; w < 16; w++) msg_q[w] <= msg_d[w];
    for (int w = 0; w < MaxHeight; w++) stack_q[w] <= stack_d[w];
  end

endmodule
